// ===== rtl/dto_pkg.sv =====
// ----------------------------------------------------------------------------
// dto_pkg
// shared constants and control types of the dependency transition oracle
// ----------------------------------------------------------------------------
package dto_pkg;

    localparam int MAX_TOKENS = 128;
    localparam int TOK_W      = 7;
    localparam int CNT_W      = 8;
    localparam int LAB_W      = 6;

    localparam logic [2:0] ADDR_PARSE_MODE   = 3'd0;
    localparam logic [2:0] ADDR_LABEL_OUTPUT = 3'd4;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_ORACLE = 2'd1;
    localparam logic [1:0] OP_GIVEN  = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [2:0] ACT_SHIFT  = 3'd0;
    localparam logic [2:0] ACT_LEFT   = 3'd1;
    localparam logic [2:0] ACT_RIGHT  = 3'd2;
    localparam logic [2:0] ACT_REDUCE = 3'd3;
    localparam logic [2:0] ACT_NONE   = 3'd4;

    localparam logic [3:0] CMD_NONE  = 4'd0;
    localparam logic [3:0] CMD_LATCH = 4'd1;
    localparam logic [3:0] CMD_LOAD  = 4'd2;
    localparam logic [3:0] CMD_CLEAR = 4'd3;
    localparam logic [3:0] CMD_RD1   = 4'd4;
    localparam logic [3:0] CMD_RD2   = 4'd5;
    localparam logic [3:0] CMD_EVAL  = 4'd6;
    localparam logic [3:0] CMD_SCAN  = 4'd7;
    localparam logic [3:0] CMD_APPLY = 4'd8;

    typedef struct packed {
        logic [3:0] code;
    } t_cmd;

    typedef struct packed {
        logic need_scan;
        logic scan_done;
    } t_status;

endpackage

// ===== rtl/dto_ctrl.sv =====
// ----------------------------------------------------------------------------
// dto_ctrl
// sequencer: runs load or clear, or read, evaluate, scan if needed, apply
// ----------------------------------------------------------------------------
module dto_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [1:0]       i_opcode,
    input  dto_pkg::t_status i_status,
    output dto_pkg::t_cmd    o_cmd,
    output logic             o_busy,
    output logic             o_done
);
    import dto_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_LOAD  = 4'd1;
    localparam logic [3:0] ST_CLEAR = 4'd2;
    localparam logic [3:0] ST_RD1   = 4'd3;
    localparam logic [3:0] ST_RD2   = 4'd4;
    localparam logic [3:0] ST_EVAL  = 4'd5;
    localparam logic [3:0] ST_SCAN  = 4'd6;
    localparam logic [3:0] ST_APPLY = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd.code = CMD_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.code = CMD_LATCH;
                    unique case (i_opcode)
                        OP_LOAD:  n_state = ST_LOAD;
                        OP_CLEAR: n_state = ST_CLEAR;
                        default:  n_state = ST_RD1;
                    endcase
                end
            end
            ST_LOAD: begin
                o_cmd.code = CMD_LOAD;
                n_state    = ST_DONE;
            end
            ST_CLEAR: begin
                o_cmd.code = CMD_CLEAR;
                n_state    = ST_DONE;
            end
            ST_RD1: begin
                o_cmd.code = CMD_RD1;
                n_state    = ST_RD2;
            end
            ST_RD2: begin
                o_cmd.code = CMD_RD2;
                n_state    = ST_EVAL;
            end
            ST_EVAL: begin
                o_cmd.code = CMD_EVAL;
                n_state    = i_status.need_scan ? ST_SCAN : ST_APPLY;
            end
            ST_SCAN: begin
                o_cmd.code = CMD_SCAN;
                if (i_status.scan_done) begin
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY: begin
                o_cmd.code = CMD_APPLY;
                n_state    = ST_DONE;
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = (r_state == ST_DONE);

endmodule

// ===== rtl/dto_dpath.sv =====
// ----------------------------------------------------------------------------
// dto_dpath
// token tables, stack and buffer memories, oracle decision and child scan
// ----------------------------------------------------------------------------
module dto_dpath (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  dto_pkg::t_cmd           i_cmd,
    output dto_pkg::t_status        o_status,
    input  logic                    i_parse_mode,
    input  logic                    i_label_output,
    input  logic [1:0]              i_opcode,
    input  logic [dto_pkg::TOK_W-1:0] i_token_index,
    input  logic [dto_pkg::TOK_W-1:0] i_gold_head,
    input  logic [dto_pkg::LAB_W-1:0] i_gold_tag,
    input  logic                    i_root_token,
    input  logic                    i_onto_stack,
    input  logic [1:0]              i_given_action,
    input  logic [dto_pkg::LAB_W-1:0] i_given_label,
    output logic [2:0]              o_action_taken,
    output logic [dto_pkg::LAB_W-1:0] o_arc_tag,
    output logic                    o_arc_valid,
    output logic [dto_pkg::TOK_W-1:0] o_arc_head,
    output logic [dto_pkg::TOK_W-1:0] o_arc_dependent,
    output logic                    o_status_bit,
    output logic [dto_pkg::CNT_W-1:0] o_stack_depth,
    output logic [dto_pkg::CNT_W-1:0] o_buffer_depth
);
    import dto_pkg::*;

    // latched transaction
    logic [1:0]       r_op;
    logic [TOK_W-1:0] r_ti, r_gh;
    logic [LAB_W-1:0] r_gl, r_glb;
    logic             r_rt, r_onto;
    logic [1:0]       r_ga;

    // memories
    logic [TOK_W-1:0] head_mem  [MAX_TOKENS];
    logic [LAB_W-1:0] label_mem [MAX_TOKENS];
    logic             root_mem  [MAX_TOKENS];
    logic             att_mem   [MAX_TOKENS];
    logic [TOK_W-1:0] stack_mem [MAX_TOKENS];
    logic [TOK_W-1:0] queue_mem [MAX_TOKENS];

    logic [CNT_W-1:0] r_sc, r_qc, r_k;
    logic [TOK_W-1:0] r_front;

    logic [TOK_W-1:0] r_srd, r_qrd, r_s, r_b, r_ha, r_hb, r_tgt;
    logic [LAB_W-1:0] r_ls, r_lb;
    logic             r_rs, r_atts, r_fl, r_fh, r_as, r_found, r_pa, r_pb;

    logic [2:0]       r_act;
    logic [LAB_W-1:0] r_lab;
    logic             r_av, r_st;
    logic [TOK_W-1:0] r_ah, r_ad;

    // ---- read addresses ----
    logic [TOK_W-1:0] stack_ra, queue_ra, head_ra;
    logic             queue_re, head_re, rd2;
    logic             scan_issue;

    assign rd2        = (i_cmd.code == CMD_RD2);
    assign scan_issue = (i_cmd.code == CMD_SCAN) && (r_k < r_qc);
    assign stack_ra   = TOK_W'(r_sc - CNT_W'(1));
    assign queue_ra   = (i_cmd.code == CMD_SCAN) ? r_front + r_k[TOK_W-1:0] : r_front;
    assign queue_re   = (i_cmd.code == CMD_RD1) || scan_issue;
    assign head_ra    = (i_cmd.code == CMD_SCAN) ? r_qrd : r_srd;
    assign head_re    = rd2 || (i_cmd.code == CMD_SCAN);

    // ---- evaluation ----
    logic f_left, f_hb, att_s, mode_std;
    assign mode_std = !i_parse_mode;
    assign f_left   = (r_ha == r_b) && !r_rs;
    assign f_hb     = (r_hb == r_s);
    assign att_s    = r_atts;

    assign o_status.need_scan = (r_op == OP_ORACLE) && (r_sc != '0) && (r_qc != '0)
                                && !f_left && (mode_std ? f_hb : (!f_hb && att_s));
    assign o_status.scan_done = (r_k >= r_qc) && !r_pa && !r_pb;

    // ---- apply ----
    logic             stk, buf_ne, room, given, err, arc_mk, push, ld_zero;
    logic [2:0]       orc, act;
    logic [TOK_W-1:0] arc_h, arc_d;
    logic [LAB_W-1:0] ld, newl;

    always_comb begin
        stk    = (r_sc != '0);
        buf_ne = (r_qc != '0);
        room   = (r_sc < CNT_W'(MAX_TOKENS));
        given  = (r_op == OP_GIVEN);
        if (!stk) begin
            orc = ACT_SHIFT;
        end else if (r_fl) begin
            orc = ACT_LEFT;
        end else if (mode_std) begin
            if (r_fh && !r_found) begin
                orc = ACT_RIGHT;
            end else if (r_qc > CNT_W'(1)) begin
                orc = ACT_SHIFT;
            end else begin
                orc = ACT_NONE;
            end
        end else if (r_fh) begin
            orc = ACT_RIGHT;
        end else if (r_as && !r_found) begin
            orc = ACT_REDUCE;
        end else begin
            orc = ACT_SHIFT;
        end

        if (given) begin
            act = {1'b0, r_ga};
        end else begin
            act = buf_ne ? orc : ACT_NONE;
        end

        case (act)
            ACT_SHIFT:  err = !buf_ne || !room;
            ACT_LEFT:   err = !stk || !buf_ne || r_rs;
            ACT_RIGHT:  err = !stk || !buf_ne || (!mode_std && !room);
            ACT_REDUCE: err = !stk || mode_std;
            default:    err = !given && !buf_ne;
        endcase

        arc_mk  = !err && ((act == ACT_LEFT) || (act == ACT_RIGHT));
        push    = !err && ((act == ACT_SHIFT) || ((act == ACT_RIGHT) && !mode_std));
        arc_h   = (act == ACT_LEFT) ? r_b : r_s;
        arc_d   = (act == ACT_LEFT) ? r_s : r_b;
        ld      = (act == ACT_LEFT) ? r_ls : r_lb;
        ld_zero = (ld == '0);
        newl    = ld_zero ? (given ? r_glb : '0) : ld;
    end

    // ---- load ----
    logic load_ok;
    assign load_ok = r_onto ? (r_sc < CNT_W'(MAX_TOKENS)) : (r_qc < CNT_W'(MAX_TOKENS));

    // ---- memory write ports ----
    logic             head_we, stack_we, queue_we, is_load, is_apply;
    logic [TOK_W-1:0] head_wa, head_wd, stack_wd, queue_wa, queue_wd;
    logic [LAB_W-1:0] label_wd;

    always_comb begin
        is_load  = (i_cmd.code == CMD_LOAD) && load_ok;
        is_apply = (i_cmd.code == CMD_APPLY);
        head_we  = is_load || (is_apply && arc_mk && ld_zero);
        head_wa  = is_load ? r_ti : arc_d;
        head_wd  = is_load ? r_gh : arc_h;
        label_wd = is_load ? r_gl : newl;
        stack_we = (is_load && r_onto) || (is_apply && push);
        stack_wd = is_load ? r_ti : r_b;
        queue_we = (is_load && !r_onto)
                   || (is_apply && !err && (act == ACT_RIGHT) && mode_std);
        queue_wa = is_load ? r_front + r_qc[TOK_W-1:0] : r_front;
        queue_wd = is_load ? r_ti : r_s;
    end

    always_ff @(posedge i_clk) begin
        if (head_we) begin
            head_mem[head_wa]  <= head_wd;
            label_mem[head_wa] <= label_wd;
        end
        if (head_re) begin
            r_ha <= head_mem[head_ra];
        end
        if (rd2) begin
            r_hb <= head_mem[r_qrd];
            r_ls <= label_mem[r_srd];
            r_lb <= label_mem[r_qrd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_load) begin
            root_mem[r_ti] <= r_rt;
        end
        if (rd2) begin
            r_rs <= root_mem[r_srd];
        end
    end

    // attached marks: every token on the stack or in the buffer was loaded
    // after the last clear, and its load clears its mark, so no bulk clear
    always_ff @(posedge i_clk) begin
        if (is_load) begin
            att_mem[r_ti] <= 1'b0;
        end else if (is_apply && arc_mk) begin
            att_mem[arc_d] <= 1'b1;
        end
        if (rd2) begin
            r_atts <= att_mem[r_srd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stack_we) begin
            stack_mem[r_sc[TOK_W-1:0]] <= stack_wd;
        end
        r_srd <= stack_mem[stack_ra];
    end

    always_ff @(posedge i_clk) begin
        if (queue_we) begin
            queue_mem[queue_wa] <= queue_wd;
        end
        if (queue_re) begin
            r_qrd <= queue_mem[queue_ra];
        end
    end

    // ---- payload registers ----
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.code)
            CMD_LATCH: begin
                r_op   <= i_opcode;
                r_ti   <= i_token_index;
                r_gh   <= i_gold_head;
                r_gl   <= i_gold_tag;
                r_rt   <= i_root_token;
                r_onto <= i_onto_stack;
                r_ga   <= i_given_action;
                r_glb  <= i_given_label;
            end
            CMD_RD2: begin
                r_s <= r_srd;
                r_b <= r_qrd;
            end
            CMD_EVAL: begin
                r_fl  <= f_left;
                r_fh  <= f_hb;
                r_as  <= att_s;
                r_tgt <= mode_std ? r_b : r_s;
                r_k   <= mode_std ? CNT_W'(1) : '0;
            end
            CMD_SCAN: begin
                if (scan_issue) begin
                    r_k <= r_k + CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // ---- control registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc    <= '0;
            r_qc    <= '0;
            r_front <= '0;
            r_pa    <= 1'b0;
            r_pb    <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_pa <= scan_issue;
            r_pb <= r_pa && (i_cmd.code == CMD_SCAN);
            if (i_cmd.code == CMD_EVAL) begin
                r_found <= 1'b0;
                r_pa    <= 1'b0;
                r_pb    <= 1'b0;
            end else if (r_pb && (r_ha == r_tgt)) begin
                r_found <= 1'b1;
            end
            if (i_cmd.code == CMD_CLEAR) begin
                r_sc    <= '0;
                r_qc    <= '0;
                r_front <= '0;
            end else if (is_load) begin
                if (r_onto) begin
                    r_sc <= r_sc + CNT_W'(1);
                end else begin
                    r_qc <= r_qc + CNT_W'(1);
                end
            end else if (is_apply && !err) begin
                if (push) begin
                    r_sc    <= r_sc + CNT_W'(1);
                    r_qc    <= r_qc - CNT_W'(1);
                    r_front <= r_front + TOK_W'(1);
                end else if (act != ACT_NONE && act != ACT_SHIFT) begin
                    r_sc <= r_sc - CNT_W'(1);
                end
            end
        end
    end

    // ---- result registers ----
    always_ff @(posedge i_clk) begin
        if (i_cmd.code == CMD_LOAD || i_cmd.code == CMD_CLEAR) begin
            r_act <= ACT_NONE;
            r_lab <= '0;
            r_av  <= 1'b0;
            r_ah  <= '0;
            r_ad  <= '0;
            r_st  <= (i_cmd.code == CMD_LOAD) && !load_ok;
        end else if (is_apply) begin
            r_act <= act;
            r_lab <= (arc_mk && i_label_output) ? newl : '0;
            r_av  <= arc_mk;
            r_ah  <= arc_mk ? arc_h : '0;
            r_ad  <= arc_mk ? arc_d : '0;
            r_st  <= err;
        end
    end

    assign o_action_taken  = r_act;
    assign o_arc_tag       = r_lab;
    assign o_arc_valid     = r_av;
    assign o_arc_head      = r_ah;
    assign o_arc_dependent = r_ad;
    assign o_status_bit    = r_st;
    assign o_stack_depth   = r_sc;
    assign o_buffer_depth  = r_qc;

endmodule

// ===== rtl/dependency_transition_oracle.sv =====
// ----------------------------------------------------------------------------
// dependency_transition_oracle
// transition-based dependency parser core with a static oracle
// ----------------------------------------------------------------------------
// a transaction is taken when start is high and busy is low; its single result
// shows on the o_ ports for one cycle with o_done high and cannot be stalled.
// load and clear pass through their load or clear state and then done. an
// oracle step or given action passes through two read states, evaluate and
// apply before done, and an oracle step that needs the child check scans the
// buffer entries in between, draining the queue-to-head-table read pipeline
// before apply. one transaction is in flight at a time. the config registers
// sit on an apb port at byte 0 (parse_mode) and byte 4 (label_output); the
// user must see that they are written only while idle, as the block does not
// enforce it.
// ----------------------------------------------------------------------------
module dependency_transition_oracle (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [6:0]  i_token_index,
    input  logic [6:0]  i_gold_head,
    input  logic [5:0]  i_gold_tag,
    input  logic        i_root_token,
    input  logic        i_onto_stack,
    input  logic [1:0]  i_given_action,
    input  logic [5:0]  i_given_label,
    // result transaction
    output logic        o_done,
    output logic [2:0]  o_action_taken,
    output logic [5:0]  o_arc_tag,
    output logic        o_arc_valid,
    output logic [6:0]  o_arc_head,
    output logic [6:0]  o_arc_dependent,
    output logic        o_status,
    output logic [7:0]  o_stack_depth,
    output logic [7:0]  o_buffer_depth,
    // apb config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dto_pkg::*;

    logic    r_parse_mode;
    logic    r_label_output;
    logic    cfg_wr;
    t_cmd    cmd;
    t_status stat;

    // config registers, written on the apb access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parse_mode   <= 1'b0;
            r_label_output <= 1'b1;
        end else if (cfg_wr) begin
            unique case (paddr)
                ADDR_PARSE_MODE:   r_parse_mode   <= pwdata[0];
                ADDR_LABEL_OUTPUT: r_label_output <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            ADDR_PARSE_MODE:   prdata = {31'b0, r_parse_mode};
            ADDR_LABEL_OUTPUT: prdata = {31'b0, r_label_output};
            default:           prdata = '0;
        endcase
    end

    // sequencer
    dto_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_status (stat),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_done   (o_done)
    );

    // tables, stack, buffer and oracle logic
    dto_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (stat),
        .i_parse_mode    (r_parse_mode),
        .i_label_output  (r_label_output),
        .i_opcode        (i_opcode),
        .i_token_index   (i_token_index),
        .i_gold_head     (i_gold_head),
        .i_gold_tag      (i_gold_tag),
        .i_root_token    (i_root_token),
        .i_onto_stack    (i_onto_stack),
        .i_given_action  (i_given_action),
        .i_given_label   (i_given_label),
        .o_action_taken  (o_action_taken),
        .o_arc_tag       (o_arc_tag),
        .o_arc_valid     (o_arc_valid),
        .o_arc_head      (o_arc_head),
        .o_arc_dependent (o_arc_dependent),
        .o_status_bit    (o_status),
        .o_stack_depth   (o_stack_depth),
        .o_buffer_depth  (o_buffer_depth)
    );

`ifndef SYNTHESIS
    // result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe longer than one cycle");

    // an accepted transaction makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("transaction accepted but not busy");

    // results only come out of a transaction in flight
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy) else $error("result strobe while idle");

    // depths shown with a result never exceed the token capacity
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_stack_depth <= 8'd128) && (o_buffer_depth <= 8'd128))
        else $error("depth beyond capacity");
`endif

endmodule

// ===== sim/tb_dependency_transition_oracle.sv =====
// ----------------------------------------------------------------------------
// tb_dependency_transition_oracle
// self-checking bench for the transition-based dependency parser core
// ----------------------------------------------------------------------------
// a queue of pending commands feeds a clocked driver. each accepted transaction
// is run through a local model of the token table, stack and buffer, and the
// predicted result is queued. a clocked monitor compares every o_done
// transaction against the oldest prediction, field by field. the run walks
// through the parse_mode / label_output settings, writing them over apb only
// while the core is idle. stimulus is mostly whole sentences parsed by oracle
// steps, mixed with given actions, noise and a stack / buffer overflow case.
// ----------------------------------------------------------------------------
module tb_dependency_transition_oracle;
    import dto_pkg::*;

    typedef struct {
        logic [1:0] opcode;
        logic [6:0] token_index;
        logic [6:0] gold_head;
        logic [5:0] gold_tag;
        logic       root_token;
        logic       onto_stack;
        logic [1:0] given_action;
        logic [5:0] given_label;
    } t_parse_cmd;

    typedef struct {
        logic [2:0] action;
        logic [5:0] label;
        logic       arc_valid;
        logic [6:0] head;
        logic [6:0] dependent;
        logic       status;
        logic [7:0] stack_depth;
        logic [7:0] buffer_depth;
    } t_parse_res;

    localparam int CYCLE_LIMIT = 600000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_opcode = '0;
    logic [6:0]  i_token_index = '0;
    logic [6:0]  i_gold_head = '0;
    logic [5:0]  i_gold_tag = '0;
    logic        i_root_token = 1'b0;
    logic        i_onto_stack = 1'b0;
    logic [1:0]  i_given_action = '0;
    logic [5:0]  i_given_label = '0;
    logic        o_done;
    logic [2:0]  o_action_taken;
    logic [5:0]  o_arc_tag;
    logic        o_arc_valid;
    logic [6:0]  o_arc_head;
    logic [6:0]  o_arc_dependent;
    logic        o_status;
    logic [7:0]  o_stack_depth;
    logic [7:0]  o_buffer_depth;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    dependency_transition_oracle dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // local model of the parser state
    // ------------------------------------------------------------------
    logic [6:0] gold_heads [MAX_TOKENS];
    logic [5:0] tok_tags [MAX_TOKENS];
    logic       is_root [MAX_TOKENS];
    logic       is_attached [MAX_TOKENS];
    logic [6:0] stack_tok [MAX_TOKENS];
    logic [6:0] buf_tok [MAX_TOKENS];
    int         stack_cnt = 0;
    int         buf_head = 0;
    int         buf_cnt = 0;
    logic       eager_mode = 1'b0;
    logic       labels_on = 1'b1;

    initial begin
        for (int k = 0; k < MAX_TOKENS; k++) begin
            gold_heads[k] = '0;
            tok_tags[k] = '0;
            is_root[k] = 1'b0;
            is_attached[k] = 1'b0;
            stack_tok[k] = '0;
            buf_tok[k] = '0;
        end
    end

    function automatic int buf_slot(int k);
        return (buf_head + k) % MAX_TOKENS;
    endfunction

    // does any buffer entry from position 'from' on have 'parent' as head
    function automatic logic buffer_child(logic [6:0] parent, int from);
        for (int k = from; k < buf_cnt; k++)
            if (gold_heads[buf_tok[buf_slot(k)]] == parent)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [2:0] oracle_pick();
        logic [6:0] s, b;
        if (stack_cnt == 0)
            return ACT_SHIFT;
        s = stack_tok[stack_cnt - 1];
        b = buf_tok[buf_slot(0)];
        if (gold_heads[s] == b && !is_root[s])
            return ACT_LEFT;
        if (!eager_mode) begin
            if (gold_heads[b] == s && !buffer_child(b, 1))
                return ACT_RIGHT;
            if (buf_cnt > 1)
                return ACT_SHIFT;
            return ACT_NONE;
        end
        if (gold_heads[b] == s)
            return ACT_RIGHT;
        if (is_attached[s] && !buffer_child(s, 0))
            return ACT_REDUCE;
        return ACT_SHIFT;
    endfunction

    function automatic void add_arc(logic [6:0] h, logic [6:0] d, logic [5:0] lab,
                                    logic given, ref t_parse_res r);
        logic [5:0] l;
        l = given ? lab : tok_tags[d];
        if (tok_tags[d] == 0) begin
            tok_tags[d] = l;
            gold_heads[d] = h;
        end
        is_attached[d] = 1'b1;
        r.arc_valid = 1'b1;
        r.head = h;
        r.dependent = d;
        r.label = labels_on ? tok_tags[d] : 6'd0;
    endfunction

    function automatic void shift_front(); 
        stack_tok[stack_cnt] = buf_tok[buf_slot(0)];
        stack_cnt++;
        buf_head = (buf_head + 1) % MAX_TOKENS;
        buf_cnt--;
    endfunction

    function automatic void apply_action(logic [2:0] act, logic [5:0] lab, logic given,
                                         ref t_parse_res r);
        logic stk, bf, room;
        logic [6:0] s, b;
        stk = stack_cnt > 0;
        bf = buf_cnt > 0;
        room = stack_cnt < MAX_TOKENS;
        r.action = act;
        case (act)
            ACT_SHIFT: begin
                if (!bf || !room) r.status = 1'b1;
                else shift_front();
            end
            ACT_LEFT: begin
                if (!stk || !bf || is_root[stack_tok[stack_cnt - 1]]) begin
                    r.status = 1'b1;
                end else begin
                    s = stack_tok[stack_cnt - 1];
                    add_arc(buf_tok[buf_slot(0)], s, lab, given, r);
                    stack_cnt--;
                end
            end
            ACT_RIGHT: begin
                if (!stk || !bf || (eager_mode && !room)) begin
                    r.status = 1'b1;
                end else begin
                    s = stack_tok[stack_cnt - 1];
                    b = buf_tok[buf_slot(0)];
                    add_arc(s, b, lab, given, r);
                    if (!eager_mode) begin
                        buf_tok[buf_slot(0)] = s;
                        stack_cnt--;
                    end else begin
                        shift_front();
                    end
                end
            end
            default: begin
                if (!stk || !eager_mode) r.status = 1'b1;
                else stack_cnt--;
            end
        endcase
    endfunction

    // advance the model by one command and return its result transaction
    function automatic t_parse_res parse_step(t_parse_cmd c);
        t_parse_res r;
        logic [2:0] act;
        r = '{ACT_NONE, 6'd0, 1'b0, 7'd0, 7'd0, 1'b0, 8'd0, 8'd0};
        case (c.opcode)
            OP_LOAD: begin
                if (c.onto_stack ? stack_cnt >= MAX_TOKENS : buf_cnt >= MAX_TOKENS) begin
                    r.status = 1'b1;
                end else begin
                    gold_heads[c.token_index] = c.gold_head;
                    tok_tags[c.token_index] = c.gold_tag;
                    is_root[c.token_index] = c.root_token;
                    is_attached[c.token_index] = 1'b0;
                    if (c.onto_stack) begin
                        stack_tok[stack_cnt] = c.token_index;
                        stack_cnt++;
                    end else begin
                        buf_tok[buf_slot(buf_cnt)] = c.token_index;
                        buf_cnt++;
                    end
                end
            end
            OP_ORACLE: begin
                if (buf_cnt == 0) begin
                    r.status = 1'b1;
                end else begin
                    act = oracle_pick();
                    if (act != ACT_NONE)
                        apply_action(act, 6'd0, 1'b0, r);
                end
            end
            OP_GIVEN: apply_action({1'b0, c.given_action}, c.given_label, 1'b1, r);
            default: begin
                for (int k = 0; k < MAX_TOKENS; k++)
                    is_attached[k] = 1'b0;
                stack_cnt = 0;
                buf_head = 0;
                buf_cnt = 0;
            end
        endcase
        r.stack_depth = stack_cnt[7:0];
        r.buffer_depth = buf_cnt[7:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // driver: issues pending commands, predicts on acceptance
    // ------------------------------------------------------------------
    t_parse_cmd pending_cmds [$];
    t_parse_res expected_results [$];
    t_parse_cmd cur_cmd;
    int         send_idle_pct = 31;
    int         error_count = 0;
    int         cycle_count = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            // transaction accepted at this edge
            if (start && !busy)
                expected_results = {expected_results, parse_step(cur_cmd)};
            if (start && busy) begin
                // hold the current command until the core takes it
            end else if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                cur_cmd = pending_cmds.pop_front();
                i_opcode <= cur_cmd.opcode;
                i_token_index <= cur_cmd.token_index;
                i_gold_head <= cur_cmd.gold_head;
                i_gold_tag <= cur_cmd.gold_tag;
                i_root_token <= cur_cmd.root_token;
                i_onto_stack <= cur_cmd.onto_stack;
                i_given_action <= cur_cmd.given_action;
                i_given_label <= cur_cmd.given_label;
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: compare each result transaction with the oldest prediction
    // ------------------------------------------------------------------
    task automatic check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_parse_res e;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with nothing expected, expected none, actual action %0d",
                         $time, o_action_taken);
                error_count++;
            end else begin
                e = expected_results.pop_front();
                check_field("action_taken", e.action, o_action_taken);
                check_field("arc_tag", e.label, o_arc_tag);
                check_field("arc_valid", e.arc_valid, o_arc_valid);
                check_field("arc_head", e.head, o_arc_head);
                check_field("arc_dependent", e.dependent, o_arc_dependent);
                check_field("status", e.status, o_status);
                check_field("stack_depth", e.stack_depth, o_stack_depth);
                check_field("buffer_depth", e.buffer_depth, o_buffer_depth);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_dependency_transition_oracle: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------
    int queued = 0;

    task automatic push_cmd(logic [1:0] op, logic [6:0] ti, logic [6:0] gh, logic [5:0] gl,
                            logic rt, logic os, logic [1:0] ga, logic [5:0] gv);
        t_parse_cmd c;
        c = '{op, ti, gh, gl, rt, os, ga, gv};
        pending_cmds = {pending_cmds, c};
        queued++;
    endtask

    task automatic push_noise();
        push_cmd(2'($urandom_range(3)), 7'($urandom_range(127)), 7'($urandom_range(127)),
                 6'($urandom_range(63)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                 2'($urandom_range(3)), 6'($urandom_range(63)));
    endtask

    function automatic logic [5:0] rand_label();
        // unknown labels are common enough that arcs relabel them
        return ($urandom_range(9) < 2) ? 6'd0 : 6'($urandom_range(1, 63));
    endfunction

    // one sentence: root on the stack, words in the buffer, then parse it
    task automatic push_sentence(int n);
        int base;
        int h;
        base = $urandom_range(127);
        push_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        push_cmd(OP_LOAD, 7'(base), 7'($urandom_range(127)), rand_label(), 1'b1, 1'b1, 0, 0);
        for (int k = 1; k <= n; k++) begin
            h = $urandom_range(n);
            if (h == k) h = 0;
            push_cmd(OP_LOAD, 7'((base + k) % 128), 7'((base + h) % 128), rand_label(),
                     1'b0, 1'b0, 0, 0);
        end
        for (int k = 0; k < 2 * n + 2; k++) begin
            if ($urandom_range(99) < 12)
                push_cmd(OP_GIVEN, 0, 0, 0, 0, 0, 2'($urandom_range(3)),
                         6'($urandom_range(63)));
            else
                push_cmd(OP_ORACLE, 0, 0, 0, 0, 0, 0, 0);
        end
    endtask

    // fill buffer and stack past capacity, then try moves on the full stack
    task automatic push_fill();
        push_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        for (int k = 0; k < MAX_TOKENS + 2; k++)
            push_cmd(OP_LOAD, 7'(k), 7'($urandom_range(127)), rand_label(), 0, 0, 0, 0);
        for (int k = 0; k < MAX_TOKENS + 2; k++)
            push_cmd(OP_LOAD, 7'(k), 7'($urandom_range(127)), rand_label(), 0, 1, 0, 0);
        push_cmd(OP_GIVEN, 0, 0, 0, 0, 0, ACT_SHIFT[1:0], 5);
        push_cmd(OP_GIVEN, 0, 0, 0, 0, 0, ACT_RIGHT[1:0], 5);
        for (int k = 0; k < 4; k++)
            push_cmd(OP_ORACLE, 0, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic push_random(int total);
        queued = 0;
        while (queued < total) begin
            if ($urandom_range(99) < 12)
                push_noise();
            else
                push_sentence(($urandom_range(9) == 0) ? $urandom_range(12, 40)
                                                       : $urandom_range(1, 8));
        end
    endtask

    // wait until the core has drained everything queued so far
    task automatic drain();
        while (pending_cmds.size() > 0 || start || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_modes(logic eager, logic labels);
        drain();
        apb_write(ADDR_PARSE_MODE, {31'd0, eager});
        apb_write(ADDR_LABEL_OUTPUT, {31'd0, labels});
        eager_mode = eager;
        labels_on = labels;
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values are checked implicitly by the first phase
        // empty-state errors
        push_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        push_cmd(OP_ORACLE, 0, 0, 0, 0, 0, 0, 0);
        push_cmd(OP_GIVEN, 0, 0, 0, 0, 0, ACT_SHIFT[1:0], 0);
        push_cmd(OP_GIVEN, 0, 0, 0, 0, 0, ACT_REDUCE[1:0], 0);
        push_cmd(OP_GIVEN, 0, 0, 0, 0, 0, ACT_LEFT[1:0], 0);
        // root on stack with extreme fields, two words in the buffer
        push_cmd(OP_LOAD, 0, 127, 63, 1, 1, 0, 0);
        push_cmd(OP_LOAD, 127, 0, 0, 0, 0, 0, 0);
        push_cmd(OP_LOAD, 1, 127, 5, 0, 0, 0, 0);
        // left-arc on root is refused, reduce refused in standard mode
        push_cmd(OP_GIVEN, 0, 0, 0, 0, 0, ACT_LEFT[1:0], 9);
        push_cmd(OP_GIVEN, 0, 0, 0, 0, 0, ACT_REDUCE[1:0], 9);
        push_cmd(OP_ORACLE, 0, 0, 0, 0, 0, 0, 0);
        push_cmd(OP_ORACLE, 0, 0, 0, 0, 0, 0, 0);
        push_cmd(OP_GIVEN, 0, 0, 0, 0, 0, ACT_RIGHT[1:0], 63);
        push_cmd(OP_ORACLE, 0, 0, 0, 0, 0, 0, 0);
        push_cmd(OP_ORACLE, 0, 0, 0, 0, 0, 0, 0);
        // standard fall-through: neither head matches and one word left
        push_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        push_cmd(OP_LOAD, 5, 9, 3, 0, 1, 0, 0);
        push_cmd(OP_LOAD, 6, 9, 0, 0, 0, 0, 0);
        push_cmd(OP_ORACLE, 0, 0, 0, 0, 0, 0, 0);
        push_cmd(OP_GIVEN, 0, 0, 0, 0, 0, ACT_SHIFT[1:0], 0);
        push_cmd(OP_GIVEN, 0, 0, 0, 0, 0, ACT_RIGHT[1:0], 0);
        push_random(120);

        // sender idles more; eager parsing without labels, plus overflow
        set_modes(1'b1, 1'b0);
        send_idle_pct = 48;
        push_fill();
        push_random(140);

        // no idling at all
        set_modes(1'b1, 1'b1);
        send_idle_pct = 0;
        push_random(140);

        set_modes(1'b0, 1'b0);
        send_idle_pct = 31;
        push_random(100);

        drain();
        if (error_count == 0)
            $display("tb_dependency_transition_oracle: done, clean");
        else
            $display("tb_dependency_transition_oracle: done, errors");
        $finish;
    end

endmodule
